/* rtl/ptt_pkg.sv */
// Package for the periodic timer table: sizes, status codes and the
// command struct broadcast along the row of timer cells. No dependencies.
`default_nettype none

package ptt_pkg;

    // table geometry
    localparam int TIMER_SLOTS   = 10;
    localparam int PERIOD_BITS   = 16;
    localparam int INTERVAL_BITS = 16;
    localparam int MASK_BITS     = 10;
    localparam int INDEX_BITS    = 4;
    localparam int STATUS_BITS   = 2;

    // width used to compare an interval against the largest period
    localparam int CMP_BITS = (PERIOD_BITS > INTERVAL_BITS) ? PERIOD_BITS : INTERVAL_BITS;
    localparam logic [CMP_BITS-1:0] PERIOD_MAX = CMP_BITS'((64'd1 << PERIOD_BITS) - 64'd1);

    // result status codes
    typedef enum logic [STATUS_BITS-1:0] {
        ST_OK        = 2'd0,
        ST_ZERO_IVL  = 2'd1,
        ST_TABLE_FULL = 2'd2
    } t_status;

    // command seen by every cell in the row
    typedef struct packed {
        logic                   tick;
        logic                   claim_en;
        logic [PERIOD_BITS-1:0] period;
    } t_cell_cmd;

    // clamp a requested interval to the period width
    function automatic logic [PERIOD_BITS-1:0] sat_period(
        input logic [INTERVAL_BITS-1:0] ivl
    );
        logic [CMP_BITS-1:0] wide;
        wide = CMP_BITS'(ivl);
        if (wide > PERIOD_MAX) begin
            return PERIOD_MAX[PERIOD_BITS-1:0];
        end
        return wide[PERIOD_BITS-1:0];
    endfunction

endpackage

`default_nettype wire

/* rtl/ptt_cell.sv */
// One timer slot: active flag, period and elapsed count.
// Passes the free-slot search token to its neighbor. Depends on ptt_pkg.
`default_nettype none

module ptt_cell (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire ptt_pkg::t_cell_cmd i_cmd,
    input  wire logic               i_search_in,
    output logic                    o_search_out,
    output logic                    o_claim,
    output logic                    o_fired
);

    logic                            r_active;
    logic [ptt_pkg::PERIOD_BITS-1:0] r_period;
    logic [ptt_pkg::PERIOD_BITS-1:0] r_elapsed;
    logic [ptt_pkg::PERIOD_BITS-1:0] n_elapsed;
    logic [ptt_pkg::PERIOD_BITS-1:0] elapsed_inc;

    // search token: reaches this cell only if every earlier slot is taken
    assign o_claim      = i_cmd.claim_en & i_search_in & ~r_active;
    assign o_search_out = i_search_in & r_active;

    // tick: count up, wrap to zero on reaching the period
    assign elapsed_inc = r_elapsed + ptt_pkg::PERIOD_BITS'(1);
    assign o_fired     = i_cmd.tick & r_active & (elapsed_inc == r_period);

    always_comb begin
        n_elapsed = r_elapsed;
        if (o_claim || o_fired) begin
            n_elapsed = '0;
        end else if (i_cmd.tick && r_active) begin
            n_elapsed = elapsed_inc;
        end
    end

    // active flag is control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active <= 1'b0;
        end else if (o_claim) begin
            r_active <= 1'b1;
        end
    end

    // slot payload
    always_ff @(posedge i_clk) begin
        r_elapsed <= n_elapsed;
        if (o_claim) begin
            r_period <= i_cmd.period;
        end
    end

endmodule

`default_nettype wire

/* rtl/periodic_timer_table.sv */
// Top level of the periodic timer table: a row of ptt_cell slots plus
// the command decode and registered result. Depends on ptt_pkg, ptt_cell.
//
// Usage:
//   A transaction is accepted on a rising edge with start high and busy low.
//   i_mode = 0 is one tick: every active slot counts up, and slots whose
//   count reaches their period are reported in o_fired_mask.
//   i_mode = 1 registers a timer with period i_interval in the lowest free
//   slot; o_slot_index gives the slot, o_status reports ok, zero interval
//   or full table.
//   The result is registered and appears in the cycle after acceptance,
//   with o_done high for exactly one cycle.
//   Throughput: one transaction per cycle. All slots update in the same
//   cycle; the free-slot search ripples through the row of cells.
//   busy is always low; the receiver cannot stall and takes each result
//   in the cycle it is shown.
//   Reset (synchronous, active low) marks every slot free and clears o_done.
`default_nettype none

module periodic_timer_table (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               start,
    output logic                                    busy,
    input  wire logic                               i_mode,
    input  wire logic [ptt_pkg::INTERVAL_BITS-1:0]  i_interval,
    output logic                                    o_done,
    output logic [ptt_pkg::MASK_BITS-1:0]           o_fired_mask,
    output logic [ptt_pkg::INDEX_BITS-1:0]          o_slot_index,
    output logic [ptt_pkg::STATUS_BITS-1:0]         o_status
);

    ptt_pkg::t_cell_cmd                    cmd;
    logic                                  ivl_zero;
    logic [ptt_pkg::TIMER_SLOTS:0]         search;
    logic [ptt_pkg::TIMER_SLOTS-1:0]       claim;
    logic [ptt_pkg::TIMER_SLOTS-1:0]       fired;
    logic [ptt_pkg::INDEX_BITS-1:0]  slot_idx;
    ptt_pkg::t_status                status;

    logic                            r_done;
    logic [ptt_pkg::MASK_BITS-1:0]   r_fired_mask;
    logic [ptt_pkg::INDEX_BITS-1:0]  r_slot_index;
    ptt_pkg::t_status                r_status;
    logic [ptt_pkg::MASK_BITS-1:0]   n_fired_mask;
    logic [ptt_pkg::INDEX_BITS-1:0]  n_slot_index;
    ptt_pkg::t_status                n_status;

    assign busy = 1'b0;

    // command decode
    assign ivl_zero     = (i_interval == '0);
    assign cmd.tick     = start & ~i_mode;
    assign cmd.claim_en = start & i_mode & ~ivl_zero;
    assign cmd.period   = ptt_pkg::sat_period(i_interval);

    // row of timer cells, search token enters at slot 0
    assign search[0] = 1'b1;

    for (genvar g = 0; g < ptt_pkg::TIMER_SLOTS; g++) begin : g_cell
        ptt_cell u_cell (
            .i_clk        (i_clk),
            .i_rst_n      (i_rst_n),
            .i_cmd        (cmd),
            .i_search_in  (search[g]),
            .o_search_out (search[g+1]),
            .o_claim      (claim[g]),
            .o_fired      (fired[g])
        );
    end

    // encode the claimed slot (at most one claim is high)
    always_comb begin
        slot_idx = '0;
        for (int k = 0; k < ptt_pkg::TIMER_SLOTS; k++) begin
            if (claim[k]) begin
                slot_idx = slot_idx | ptt_pkg::INDEX_BITS'(k);
            end
        end
    end

    // status for a register transaction
    always_comb begin
        priority if (ivl_zero) begin
            status = ptt_pkg::ST_ZERO_IVL;
        end else if (search[ptt_pkg::TIMER_SLOTS]) begin
            status = ptt_pkg::ST_TABLE_FULL;
        end else begin
            status = ptt_pkg::ST_OK;
        end
    end

    // result fields
    always_comb begin
        n_fired_mask = '0;
        n_slot_index = '0;
        n_status     = ptt_pkg::ST_OK;
        if (i_mode) begin
            n_status     = status;
            n_slot_index = slot_idx;
        end else begin
            for (int k = 0; k < ptt_pkg::TIMER_SLOTS && k < ptt_pkg::MASK_BITS; k++) begin
                n_fired_mask[k] = fired[k];
            end
        end
    end

    // result strobe
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done <= 1'b0;
        end else begin
            r_done <= start;
        end
    end

    // result payload
    always_ff @(posedge i_clk) begin
        if (start) begin
            r_fired_mask <= n_fired_mask;
            r_slot_index <= n_slot_index;
            r_status     <= n_status;
        end
    end

    assign o_done       = r_done;
    assign o_fired_mask = r_fired_mask;
    assign o_slot_index = r_slot_index;
    assign o_status     = r_status;

endmodule

`default_nettype wire
